// File: src/ghp_pkg.sv
// ----------------------------------------------------------------------------
// Generational handle pool package
// Shared widths, command codes, sequencer states and the structs that pass
// between the sequencer, the slot store and the top level.
// ----------------------------------------------------------------------------
package ghp_pkg;

	localparam int CAPACITY = 1024;
	localparam int IDX_W    = 10;
	localparam int PTR_W    = 11;
	localparam int AGE_W    = 32;
	localparam int CMD_W    = 3;

	localparam logic [PTR_W-1:0] LIST_END = PTR_W'(CAPACITY);
	localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(CAPACITY - 1);

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC   = 3'd0,
		CMD_FREE    = 3'd1,
		CMD_CHECK   = 3'd2,
		CMD_ACQUIRE = 3'd3,
		CMD_LOOKUP  = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_WALK_ADDR,
		ST_WALK_DATA
	} state_t;

	// write and read requests toward the slot store
	typedef struct packed {
		logic [IDX_W-1:0] rd_addr;
		logic             age_we;
		logic [IDX_W-1:0] age_wa;
		logic [AGE_W-1:0] age_wd;
		logic             link_we;
		logic [IDX_W-1:0] link_wa;
		logic [PTR_W-1:0] link_wd;
		logic             busy_we;
		logic [IDX_W-1:0] busy_wa;
		logic             busy_wd;
	} mem_req_t;

	// registered read data from the slot store
	typedef struct packed {
		logic [AGE_W-1:0] age;
		logic [PTR_W-1:0] link;
		logic             busy;
	} mem_rd_t;

	// one finished command
	typedef struct packed {
		logic             valid;
		logic             ok;
		logic [IDX_W-1:0] index;
		logic [AGE_W-1:0] age;
		logic [PTR_W-1:0] count;
	} res_t;

endpackage

// File: src/generational_handle_pool_unit.sv
// ----------------------------------------------------------------------------
// Generational handle pool unit
// Fixed pool of 1024 handle slots with per-slot generation and a LIFO free
// list; allocate, free, check, acquire and lookup commands.
// ----------------------------------------------------------------------------
// After reset the unit holds busy high while it initializes the slot store
// (generation 1, free order 0 to 1023). A command is taken when start is
// high and busy is low. Allocate, free, check, lookup and unknown commands
// read the slot store through its registered read, form the result in the
// execute state and register done from it. Acquire reads the slot too,
// then walks the free list toward the named slot, one read of the link
// memory per link. The result stands on ok, result_index, result_age and
// free_count for the one cycle that done is high; there is no way to hold
// it, so the receiver must take it then. busy drops together with done,
// and a new command may start in that cycle.
module generational_handle_pool_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [ghp_pkg::CMD_W-1:0] command,
	input  logic [ghp_pkg::IDX_W-1:0] handle_index,
	input  logic [ghp_pkg::AGE_W-1:0] handle_gen,
	output logic                      done,
	output logic                      ok,
	output logic [ghp_pkg::IDX_W-1:0] result_index,
	output logic [ghp_pkg::AGE_W-1:0] result_age,
	output logic [ghp_pkg::PTR_W-1:0] free_count
);

	ghp_pkg::mem_req_t req;
	ghp_pkg::mem_rd_t  rd;
	ghp_pkg::res_t     res;
	logic              seq_busy;

	logic                      done_q;
	logic                      ok_q;
	logic [ghp_pkg::IDX_W-1:0] index_q;
	logic [ghp_pkg::AGE_W-1:0] age_q;
	logic [ghp_pkg::PTR_W-1:0] count_q;

	ghp_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.command      (command),
		.handle_index (handle_index),
		.handle_gen   (handle_gen),
		.rd           (rd),
		.req          (req),
		.res          (res),
		.busy         (seq_busy)
	);

	ghp_store u_store (
		.clk (clk),
		.req (req),
		.rd  (rd)
	);

	// strobe the transfer of a finished command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= res.valid;
		end
	end

	// hold the result payload
	always_ff @(posedge clk) begin
		if (res.valid) begin
			ok_q    <= res.ok;
			index_q <= res.index;
			age_q   <= res.age;
			count_q <= res.count;
		end
	end

	assign busy         = seq_busy;
	assign done         = done_q;
	assign ok           = ok_q;
	assign result_index = index_q;
	assign result_age   = age_q;
	assign free_count   = count_q;

endmodule

// File: src/ghp_store.sv
// ----------------------------------------------------------------------------
// Generational handle pool slot store
// Three single-port-write memories: slot generation, free-list link and
// in-use bit. All share one read address; read data is registered.
// ----------------------------------------------------------------------------
module ghp_store (
	input  logic              clk,
	input  ghp_pkg::mem_req_t req,
	output ghp_pkg::mem_rd_t  rd
);

	logic [ghp_pkg::AGE_W-1:0] age_mem  [ghp_pkg::CAPACITY];
	logic [ghp_pkg::PTR_W-1:0] link_mem [ghp_pkg::CAPACITY];
	logic                      busy_mem [ghp_pkg::CAPACITY];

	logic [ghp_pkg::AGE_W-1:0] age_rd_q;
	logic [ghp_pkg::PTR_W-1:0] link_rd_q;
	logic                      busy_rd_q;

	// generation memory
	always_ff @(posedge clk) begin
		if (req.age_we) begin
			age_mem[req.age_wa] <= req.age_wd;
		end
		age_rd_q <= age_mem[req.rd_addr];
	end

	// free-list link memory
	always_ff @(posedge clk) begin
		if (req.link_we) begin
			link_mem[req.link_wa] <= req.link_wd;
		end
		link_rd_q <= link_mem[req.rd_addr];
	end

	// in-use bit memory
	always_ff @(posedge clk) begin
		if (req.busy_we) begin
			busy_mem[req.busy_wa] <= req.busy_wd;
		end
		busy_rd_q <= busy_mem[req.rd_addr];
	end

	assign rd.age  = age_rd_q;
	assign rd.link = link_rd_q;
	assign rd.busy = busy_rd_q;

endmodule

// File: src/ghp_seq.sv
// ----------------------------------------------------------------------------
// Generational handle pool sequencer
// Clears the store after reset, then runs one command at a time: a read of
// the named slot (the free head for allocate), then the update; acquire
// walks the free list one link at a time, in an address and a data state.
// ----------------------------------------------------------------------------
module ghp_seq (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [ghp_pkg::CMD_W-1:0] command,
	input  logic [ghp_pkg::IDX_W-1:0] handle_index,
	input  logic [ghp_pkg::AGE_W-1:0] handle_gen,
	input  ghp_pkg::mem_rd_t          rd,
	output ghp_pkg::mem_req_t         req,
	output ghp_pkg::res_t             res,
	output logic                      busy
);

	ghp_pkg::state_t state_q, state_d;

	logic [ghp_pkg::CMD_W-1:0] cmd_q;
	logic [ghp_pkg::IDX_W-1:0] idx_q;
	logic [ghp_pkg::AGE_W-1:0] age_q;
	logic [ghp_pkg::PTR_W-1:0] head_q, head_d;
	logic [ghp_pkg::PTR_W-1:0] total_q, total_d;
	logic [ghp_pkg::PTR_W-1:0] cur_q, cur_d;
	logic [ghp_pkg::PTR_W-1:0] prev_q, prev_d;
	logic [ghp_pkg::PTR_W-1:0] steps_q, steps_d;
	logic [ghp_pkg::IDX_W-1:0] clr_q;

	logic                      accept;
	logic                      idx_in_range;
	logic                      age_nz;
	logic                      age_match;
	logic                      alloc_ok;
	logic                      free_ok;
	logic                      acq_pre;
	logic                      walk_end;
	logic                      walk_hit;
	logic [ghp_pkg::AGE_W-1:0] age_bump;

	assign accept       = (state_q == ghp_pkg::ST_IDLE) && start;
	assign busy         = (state_q != ghp_pkg::ST_IDLE);
	assign idx_in_range = ({1'b0, idx_q} < ghp_pkg::LIST_END);
	assign age_nz       = (age_q != '0);
	// shared generation compare
	assign age_match    = (rd.age == age_q);
	assign alloc_ok     = (total_q != '0) && (head_q < ghp_pkg::LIST_END);
	assign free_ok      = age_nz && idx_in_range && rd.busy && age_match;
	assign acq_pre      = age_nz && idx_in_range && !rd.busy;
	assign walk_end     = (cur_q >= ghp_pkg::LIST_END) || (steps_q >= ghp_pkg::LIST_END);
	assign walk_hit     = (cur_q == {1'b0, idx_q});
	assign age_bump     = (rd.age == '1) ? ghp_pkg::AGE_W'(1) : rd.age + 1'b1;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ghp_pkg::ST_CLEAR: begin
				if (clr_q == ghp_pkg::CLR_LAST) begin
					state_d = ghp_pkg::ST_IDLE;
				end
			end
			ghp_pkg::ST_IDLE: begin
				if (start) begin
					state_d = ghp_pkg::ST_EXEC;
				end
			end
			ghp_pkg::ST_EXEC: begin
				if ((cmd_q == ghp_pkg::CMD_ACQUIRE) && acq_pre) begin
					state_d = ghp_pkg::ST_WALK_ADDR;
				end else begin
					state_d = ghp_pkg::ST_IDLE;
				end
			end
			ghp_pkg::ST_WALK_ADDR: begin
				if (walk_end) begin
					state_d = ghp_pkg::ST_IDLE;
				end else begin
					state_d = ghp_pkg::ST_WALK_DATA;
				end
			end
			ghp_pkg::ST_WALK_DATA: begin
				if (walk_hit) begin
					state_d = ghp_pkg::ST_IDLE;
				end else begin
					state_d = ghp_pkg::ST_WALK_ADDR;
				end
			end
			default: state_d = ghp_pkg::ST_IDLE;
		endcase
	end

	// memory requests, pointer updates and result
	always_comb begin
		req        = '0;
		res        = '0;
		head_d     = head_q;
		total_d    = total_q;
		cur_d      = cur_q;
		prev_d     = prev_q;
		steps_d    = steps_q;
		res.count  = total_q;
		req.rd_addr = idx_q;
		case (state_q)
			ghp_pkg::ST_CLEAR: begin
				req.age_we  = 1'b1;
				req.age_wa  = clr_q;
				req.age_wd  = ghp_pkg::AGE_W'(1);
				req.link_we = 1'b1;
				req.link_wa = clr_q;
				req.link_wd = {1'b0, clr_q} + 1'b1;
				req.busy_we = 1'b1;
				req.busy_wa = clr_q;
				req.busy_wd = 1'b0;
			end
			ghp_pkg::ST_IDLE: begin
				// address the slot for the command being taken
				if (command == ghp_pkg::CMD_ALLOC) begin
					req.rd_addr = head_q[ghp_pkg::IDX_W-1:0];
				end else begin
					req.rd_addr = handle_index;
				end
			end
			ghp_pkg::ST_EXEC: begin
				case (cmd_q)
					ghp_pkg::CMD_ALLOC: begin
						res.valid = 1'b1;
						if (alloc_ok) begin
							head_d      = rd.link;
							total_d     = total_q - 1'b1;
							req.busy_we = 1'b1;
							req.busy_wa = head_q[ghp_pkg::IDX_W-1:0];
							req.busy_wd = 1'b1;
							res.ok      = 1'b1;
							res.index   = head_q[ghp_pkg::IDX_W-1:0];
							res.age     = rd.age;
						end
					end
					ghp_pkg::CMD_FREE: begin
						res.valid = 1'b1;
						if (free_ok) begin
							req.age_we  = 1'b1;
							req.age_wa  = idx_q;
							req.age_wd  = age_bump;
							req.link_we = 1'b1;
							req.link_wa = idx_q;
							req.link_wd = head_q;
							req.busy_we = 1'b1;
							req.busy_wa = idx_q;
							req.busy_wd = 1'b0;
							head_d      = {1'b0, idx_q};
							total_d     = total_q + 1'b1;
							res.ok      = 1'b1;
						end
					end
					ghp_pkg::CMD_CHECK: begin
						res.valid = 1'b1;
						res.ok    = age_nz && idx_in_range && age_match;
					end
					ghp_pkg::CMD_ACQUIRE: begin
						if (acq_pre) begin
							// start the walk at the free head
							cur_d   = head_q;
							prev_d  = ghp_pkg::LIST_END;
							steps_d = '0;
						end else begin
							res.valid = 1'b1;
						end
					end
					ghp_pkg::CMD_LOOKUP: begin
						res.valid = 1'b1;
						if (idx_in_range) begin
							res.ok    = 1'b1;
							res.index = idx_q;
							res.age   = rd.age;
						end
					end
					default: begin
						res.valid = 1'b1;
					end
				endcase
			end
			ghp_pkg::ST_WALK_ADDR: begin
				req.rd_addr = cur_q[ghp_pkg::IDX_W-1:0];
				if (walk_end) begin
					res.valid = 1'b1;
				end
			end
			ghp_pkg::ST_WALK_DATA: begin
				req.rd_addr = cur_q[ghp_pkg::IDX_W-1:0];
				if (walk_hit) begin
					// unlink the target and claim it
					if (prev_q == ghp_pkg::LIST_END) begin
						head_d = rd.link;
					end else begin
						req.link_we = 1'b1;
						req.link_wa = prev_q[ghp_pkg::IDX_W-1:0];
						req.link_wd = rd.link;
					end
					req.age_we  = 1'b1;
					req.age_wa  = idx_q;
					req.age_wd  = age_q;
					req.busy_we = 1'b1;
					req.busy_wa = idx_q;
					req.busy_wd = 1'b1;
					if (total_q != '0) begin
						total_d = total_q - 1'b1;
					end
					res.valid = 1'b1;
					res.ok    = 1'b1;
				end else begin
					prev_d  = cur_q;
					cur_d   = rd.link;
					steps_d = steps_q + 1'b1;
				end
			end
			default: begin
				req.rd_addr = idx_q;
			end
		endcase
		res.count = total_d;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ghp_pkg::ST_CLEAR;
			clr_q   <= '0;
			head_q  <= '0;
			total_q <= ghp_pkg::LIST_END;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			total_q <= total_d;
			if (state_q == ghp_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
		end
	end

	// command and walk registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= command;
			idx_q <= handle_index;
			age_q <= handle_gen;
		end
		cur_q   <= cur_d;
		prev_q  <= prev_d;
		steps_q <= steps_d;
	end

endmodule
